[design/ssc_pkg.sv]
`default_nettype none

package ssc_pkg;

  // word kinds on the input channel
  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_SAFE = 2'd2;

  // result status codes, in order of precedence
  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_SYS   = 3'd1;
  localparam logic [2:0] STAT_IFACE = 3'd2;
  localparam logic [2:0] STAT_ANGLE = 3'd3;
  localparam logic [2:0] STAT_CRC   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_POLY   = 2'd0;
  localparam logic [1:0] CFG_SEED   = 2'd1;
  localparam logic [1:0] CFG_SYS_EN = 2'd2;

  // reset values
  localparam logic [7:0] CRC_POLY_RST = 8'h1D;
  localparam logic [7:0] CRC_SEED_RST = 8'hFF;

  // safety word status bit positions
  localparam int BIT_SYSTEM = 14;
  localparam int BIT_IFACE  = 13;
  localparam int BIT_ANGLE  = 12;

  localparam logic [7:0] CRC_MSB = 8'h80;

  typedef struct packed {
    logic [7:0] poly;
    logic [7:0] seed;
    logic       sys_en;
  } ssc_cfg_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] computed_crc;
    logic       reset_request;
  } ssc_res_t;

  // one byte through the CRC-8, MSB first, non-reflected
  function automatic logic [7:0] fold_byte(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/ssc_in_if.sv]
`default_nettype none

interface ssc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] word;

  modport source (output valid, output mode, output word, input ready);
  modport sink   (input valid, input mode, input word, output ready);
endinterface

`default_nettype wire

[design/ssc_out_if.sv]
`default_nettype none

interface ssc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] computed_crc;
  logic       reset_request;

  modport source (output valid, output status, output computed_crc, output reset_request,
                  input ready);
  modport sink   (input valid, input status, input computed_crc, input reset_request,
                  output ready);
endinterface

`default_nettype wire

[design/sensor_safety_word_crc_check_top.sv]
`default_nettype none

// Safety-word CRC checker for a sensor SPI frame. Command, data and safety
// words arrive one per transaction on in_ch; each command word restarts the CRC
// from the seed register and is folded in, each data word is folded in high
// byte first, and each safety word yields one result on out_ch (status, inverted
// CRC and a reset request on a CRC mismatch). Mode 3 words are dropped. The
// block takes one word per cycle, but a safety word waits in the input stage
// while an earlier result is pending; its result is registered as it leaves.
// The running CRC register's 16-bit fold is combinational, and the output
// register lets other words in while a result waits. Configuration writes are
// applied at once and should only be made while no words are in flight.

module sensor_safety_word_crc_check_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  ssc_in_if.sink          in_ch,
  ssc_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);
  import ssc_pkg::*;

  ssc_cfg_t    cfg;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [1:0]  s1_mode_r;
  logic [15:0] s1_word_r;
  logic        s1_adv;
  logic        s1_safe;
  logic        in_take;
  logic [7:0]  crc;
  ssc_res_t    res;
  logic        out_valid_r;
  logic        out_valid_nxt;
  ssc_res_t    out_res_r;

  ssc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ssc_crc_unit u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .mode  (s1_mode_r),
    .word  (s1_word_r),
    .cfg   (cfg),
    .crc   (crc)
  );

  ssc_check u_check (
    .crc    (crc),
    .word   (s1_word_r),
    .sys_en (cfg.sys_en),
    .res    (res)
  );

  // input stage: drains unless a safety result has nowhere to go
  assign s1_safe  = (s1_mode_r == MODE_SAFE);
  assign s1_adv   = s1_valid_r && (!s1_safe || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_ch.mode;
      s1_word_r <= in_ch.word;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_safe) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_safe) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.computed_crc  = out_res_r.computed_crc;
  assign out_ch.reset_request = out_res_r.reset_request;

`ifndef SYNTHESIS
  // reset request travels with a CRC mismatch and nothing else
  a_rst_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.reset_request == (out_res_r.status == STAT_CRC)))
    else $error("reset request does not match status");

  // a held input stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_word_r) && $stable(s1_mode_r)))
    else $error("stalled input stage lost its transaction");

  // safety and unused words leave the running CRC alone
  a_crc_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_mode_r != MODE_CMD && s1_mode_r != MODE_DATA) |=> $stable(crc))
    else $error("running CRC changed on a non-folding word");

  // a pending result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(s1_adv && s1_safe))
    else $error("result register overrun");

  // back-pressure only when the input stage is occupied
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_safe && out_valid_r))
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

[design/ssc_cfg_regs.sv]
`default_nettype none

module ssc_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_wdata,
  output ssc_pkg::ssc_cfg_t      cfg
);
  import ssc_pkg::*;

  ssc_cfg_t cfg_r;
  ssc_cfg_t cfg_nxt;

  // register write decode; an index beyond the list is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLY:   cfg_nxt.poly   = cfg_wdata;
        CFG_SEED:   cfg_nxt.seed   = cfg_wdata;
        CFG_SYS_EN: cfg_nxt.sys_en = cfg_wdata[0];
        default:    cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly   <= CRC_POLY_RST;
      cfg_r.seed   <= CRC_SEED_RST;
      cfg_r.sys_en <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[design/ssc_crc_unit.sv]
`default_nettype none

module ssc_crc_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic [1:0]        mode,
  input  wire logic [15:0]       word,
  input  wire ssc_pkg::ssc_cfg_t cfg,
  output logic [7:0]             crc
);
  import ssc_pkg::*;

  logic [7:0] crc_r;
  logic [7:0] crc_nxt;
  logic [7:0] base;
  logic [7:0] hi_crc;
  logic [7:0] word_crc;

  // fold high byte then low byte, starting from the seed on a command word
  always_comb begin
    base     = (mode == MODE_CMD) ? cfg.seed : crc_r;
    hi_crc   = fold_byte(base, word[15:8], cfg.poly);
    word_crc = fold_byte(hi_crc, word[7:0], cfg.poly);
    crc_nxt  = crc_r;
    if (adv && (mode == MODE_CMD || mode == MODE_DATA)) begin
      crc_nxt = word_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_SEED_RST;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

`default_nettype wire

[design/ssc_check.sv]
`default_nettype none

module ssc_check (
  input  wire logic [7:0]   crc,
  input  wire logic [15:0]  word,
  input  wire logic         sys_en,
  output ssc_pkg::ssc_res_t res
);
  import ssc_pkg::*;

  logic [7:0] computed;

  // status bits in fixed precedence, CRC compare last
  always_comb begin
    computed = ~crc;
    if (sys_en && !word[BIT_SYSTEM]) begin
      res.status = STAT_SYS;
    end else if (!word[BIT_IFACE]) begin
      res.status = STAT_IFACE;
    end else if (!word[BIT_ANGLE]) begin
      res.status = STAT_ANGLE;
    end else if (computed != word[7:0]) begin
      res.status = STAT_CRC;
    end else begin
      res.status = STAT_OK;
    end
    res.computed_crc  = computed;
    res.reset_request = (res.status == STAT_CRC);
  end

endmodule

`default_nettype wire

[bench/tb_sensor_safety_word_crc_check_top.sv]
`timescale 1ns / 100ps

module tb_sensor_safety_word_crc_check_top;
  import ssc_pkg::*;

  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         RANDOM_WORDS  = 2000;
  localparam int         PHASES        = 6;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  ssc_in_if  in_ch ();
  ssc_out_if out_ch ();

  sensor_safety_word_crc_check_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // checker's own copy of the registers and the running CRC
  logic [7:0] mdl_poly;
  logic [7:0] mdl_seed;
  logic       mdl_sys_en;
  logic [7:0] mdl_crc;

  ssc_res_t   pending_checks[$];
  ssc_res_t   head_check;
  int         error_count;
  int         cycle_count;
  int         stall_left;
  int         words_sent;
  bit         no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // CRC-8, MSB first, non-reflected, current polynomial
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) c = c[7] ? ((c << 1) ^ mdl_poly) : (c << 1);
    return c;
  endfunction

  function automatic logic [7:0] crc8_word(input logic [7:0] crc, input logic [15:0] w);
    return crc8_byte(crc8_byte(crc, w[15:8]), w[7:0]);
  endfunction

  // advance the CRC copy; a safety word queues the check result it should give
  function automatic void predict_word(input logic [1:0] m, input logic [15:0] w);
    ssc_res_t   r;
    logic [7:0] inv;
    case (m)
      MODE_CMD:  mdl_crc = crc8_word(mdl_seed, w);
      MODE_DATA: mdl_crc = crc8_word(mdl_crc, w);
      MODE_SAFE: begin
        inv = ~mdl_crc;
        r.computed_crc = inv;
        if (mdl_sys_en && !w[BIT_SYSTEM]) r.status = STAT_SYS;
        else if (!w[BIT_IFACE])           r.status = STAT_IFACE;
        else if (!w[BIT_ANGLE])           r.status = STAT_ANGLE;
        else if (inv != w[7:0])           r.status = STAT_CRC;
        else                              r.status = STAT_OK;
        r.reset_request = (r.status == STAT_CRC);
        pending_checks.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // safety word that passes every check against the current CRC
  function automatic logic [15:0] good_safety();
    logic [15:0] w;
    w = 16'($urandom);
    w[BIT_SYSTEM] = 1'b1;
    w[BIT_IFACE]  = 1'b1;
    w[BIT_ANGLE]  = 1'b1;
    w[7:0]        = ~mdl_crc;
    return w;
  endfunction

  // mostly short pauses, a few long ones
  function automatic int pick_pause();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
    error_count++;
  endtask

  // result side: random stalls, each accepted transaction compared with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_checks.size() == 0) begin
        report_mismatch("unexpected result, status", 0, int'(out_ch.status));
      end else begin
        head_check = pending_checks.pop_front();
        if (out_ch.status !== head_check.status)
          report_mismatch("status", int'(head_check.status), int'(out_ch.status));
        if (out_ch.computed_crc !== head_check.computed_crc)
          report_mismatch("computed_crc", int'(head_check.computed_crc),
                          int'(out_ch.computed_crc));
        if (out_ch.reset_request !== head_check.reset_request)
          report_mismatch("reset_request", int'(head_check.reset_request),
                          int'(out_ch.reset_request));
      end
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_pause();
      out_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // one transaction on the input channel; valid stays high when the next follows at once
  task automatic send_word(input logic [1:0] m, input logic [15:0] w);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.word  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_word(m, w);
    if (m != MODE_UNUSED) words_sent++;
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_POLY:   mdl_poly   = val;
      CFG_SEED:   mdl_seed   = val;
      CFG_SYS_EN: mdl_sys_en = val[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] poly, input logic [7:0] seed, input logic sys_en);
    wait_idle();
    write_register(CFG_POLY, poly);
    write_register(CFG_SEED, seed);
    write_register(CFG_SYS_EN, {7'd0, sys_en});
  endtask

  // reset values, data before any command, repeated safety word, ignored mode
  task automatic test_reset_defaults();
    send_word(MODE_DATA, 16'h1234);
    send_word(MODE_SAFE, good_safety());
    send_word(MODE_SAFE, good_safety());
    send_word(MODE_CMD, 16'hFFFF);
    send_word(MODE_UNUSED, 16'hFFFF);
    send_word(MODE_DATA, 16'h0000);
    send_word(MODE_SAFE, good_safety() ^ 16'h0001);
    wait_idle();
  endtask

  // status precedence with the system check off and on
  task automatic test_status_order();
    send_word(MODE_CMD, 16'h8001);
    send_word(MODE_SAFE, good_safety() & ~(16'h1 << BIT_SYSTEM));
    send_word(MODE_SAFE, good_safety() & ~(16'h1 << BIT_IFACE) & ~(16'h1 << BIT_ANGLE));
    send_word(MODE_SAFE, (good_safety() & ~(16'h1 << BIT_ANGLE)) ^ 16'h0080);
    wait_idle();
    write_register(CFG_SYS_EN, 8'd1);
    send_word(MODE_SAFE, 16'h0000);
    send_word(MODE_SAFE, good_safety() & ~(16'h1 << BIT_IFACE));
    send_word(MODE_SAFE, 16'hFFFF);
    send_word(MODE_SAFE, good_safety());
  endtask

  // register extremes and a seed change in the middle of a frame
  task automatic test_config_extremes();
    set_config(8'h00, 8'h00, 1'b1);
    send_word(MODE_CMD, 16'h0000);
    send_word(MODE_SAFE, good_safety());
    set_config(8'hFF, 8'hFF, 1'b0);
    send_word(MODE_CMD, 16'hFFFF);
    send_word(MODE_DATA, 16'h5AA5);
    wait_idle();
    write_register(CFG_SEED, 8'h5A);
    send_word(MODE_SAFE, good_safety());
    send_word(MODE_CMD, 16'h1234);
    send_word(MODE_SAFE, good_safety());
  endtask

  // command, a few data words, then a safety word that is mostly right
  task automatic send_frame();
    int          n;
    int          pick;
    logic [15:0] w;
    send_word(MODE_CMD, 16'($urandom));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
    repeat (n) send_word(MODE_DATA, 16'($urandom));
    pick = $urandom_range(0, 9);
    w = good_safety();
    if (pick >= 9) w = 16'($urandom);
    else if (pick >= 7) w[$urandom_range(0, 7)] ^= 1'b1;
    else if (pick >= 5) w[BIT_ANGLE + $urandom_range(0, 2)] = 1'b0;
    send_word(MODE_SAFE, w);
  endtask

  // random frames and noise over several register settings
  task automatic test_random();
    int target;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_config(CRC_POLY_RST, CRC_SEED_RST, 1'b0);
        1:       set_config(8'h00, 8'hFF, 1'b1);
        2:       set_config(8'hFF, 8'h00, 1'b0);
        default: set_config(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      endcase
      // one phase runs flat out on both sides
      no_idle = (p == 1);
      target  = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < target) begin
        if ($urandom_range(0, 99) < 85) send_frame();
        else send_word(2'($urandom_range(0, 3)), 16'($urandom));
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_POLY;
    cfg_wdata   = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.mode  = MODE_CMD;
    in_ch.word  = 16'h0000;
    out_ch.ready = 1'b0;
    mdl_poly    = CRC_POLY_RST;
    mdl_seed    = CRC_SEED_RST;
    mdl_sys_en  = 1'b0;
    mdl_crc     = CRC_SEED_RST;
    error_count = 0;
    cycle_count = 0;
    stall_left  = 0;
    words_sent  = 0;
    no_idle     = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_status_order();
    test_config_extremes();
    test_random();

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
